// ----- rtl/arfp_pkg.sv -----
// Shared types, constants and helpers for the receive frame parser.
// Used by arfp_ctrl, arfp_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps

package arfp_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [1:0] FIELD_ADDR = 2'd1;
    localparam logic [1:0] FIELD_DATA = 2'd3;
    localparam logic [15:0] ADDR_MAX  = 16'hFFFF;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic load;
        logic clear_line;
    } t_dp_cmd;

    typedef struct packed {
        logic eol;
        logic line_nonempty;
        logic frame_ok;
        logic emit_last;
        logic out_free;
    } t_dp_status;

    // Expected character at each position of the "+RCV=" header.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h52;
            3'd2:    ch = 8'h43;
            3'd3:    ch = 8'h56;
            3'd4:    ch = 8'h3D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Returns {is_hex, nibble}.
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            res = {1'b1, ch[3:0]};
        end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
            res = {1'b1, ch[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage

// ----- rtl/arfp_ctrl.sv -----
// Controller state machine of the receive frame parser.
// Depends on arfp_pkg; drives commands into arfp_dp and reads its status.
`timescale 1ns / 1ps

module arfp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  arfp_pkg::t_dp_status i_status,
    output arfp_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall
);
    import arfp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.eol && i_status.line_nonempty &&
                    i_status.frame_ok) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
                o_cmd.clear_line = i_in_valid && i_status.eol &&
                                   i_status.line_nonempty && !i_status.frame_ok;
            end
            ST_EMIT: begin
                o_cmd.load       = i_status.out_free;
                o_cmd.clear_line = i_status.out_free && i_status.emit_last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // A good frame end always starts emission.
    a_good_eol_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_status.eol && i_status.line_nonempty && i_status.frame_ok)
        |=> (r_state == ST_EMIT))
        else $error("good frame end did not start emission");

    // No byte is loaded out while idle.
    a_no_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_cmd.load)
        else $error("load issued while idle");

endmodule

// ----- rtl/arfp_dp.sv -----
// Datapath of the receive frame parser: line state, payload memory and output register.
// Depends on arfp_pkg; commanded by arfp_ctrl.
`timescale 1ns / 1ps

module arfp_dp #(
    parameter int LINE_LIMIT  = 1024,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  arfp_pkg::t_dp_cmd    i_cmd,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_out_stall,
    output arfp_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output logic [15:0]          o_sender_address,
    output logic [7:0]           o_data_byte,
    output logic                 o_last_byte
);
    import arfp_pkg::*;

    localparam int LW = $clog2(LINE_LIMIT);
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [LW-1:0] r_len,     n_len;
    logic [2:0]    r_prefix,  n_prefix;
    logic [1:0]    r_field,   n_field;
    logic          r_inside,  n_inside;
    logic [15:0]   r_addr,    n_addr;
    logic          r_stopped, n_stopped;
    logic [3:0]    r_high,    n_high;
    logic          r_phase,   n_phase;
    logic [CW-1:0] r_count,   n_count;
    logic          r_bad,     n_bad;
    logic [CW-1:0] r_emit_idx;
    logic          r_valid;
    logic [7:0]    r_mem [MAX_PAYLOAD];

    logic          w_eol;
    logic          w_we;
    logic [7:0]    w_wdata;
    logic [4:0]    w_hex;
    logic [19:0]   w_addr_sum;
    logic [1:0]    w_fld;
    logic          w_skip;
    logic          w_emit_last;

    assign w_eol       = (i_rx_byte == CHAR_CR) || (i_rx_byte == CHAR_LF);
    assign w_hex       = hex_value(i_rx_byte);
    assign w_addr_sum  = 20'({r_addr, 3'b000}) + 20'({r_addr, 1'b0}) + 20'(i_rx_byte[3:0]);
    assign w_emit_last = (CW'(r_emit_idx + CW'(1)) == r_count);

    assign o_status.eol           = w_eol;
    assign o_status.line_nonempty = (r_len != '0);
    assign o_status.frame_ok      = !r_bad && (r_field == FIELD_DATA) && !r_phase &&
                                    (r_count != '0);
    assign o_status.emit_last     = w_emit_last;
    assign o_status.out_free      = !r_valid || !i_out_stall;

    always_comb begin
        n_len     = r_len;
        n_prefix  = r_prefix;
        n_field   = r_field;
        n_inside  = r_inside;
        n_addr    = r_addr;
        n_stopped = r_stopped;
        n_high    = r_high;
        n_phase   = r_phase;
        n_count   = r_count;
        n_bad     = r_bad;
        w_we      = 1'b0;
        w_wdata   = {r_high, w_hex[3:0]};
        w_fld     = r_field;
        w_skip    = 1'b0;

        if (i_cmd.take && !w_eol) begin
            if (r_len < LW'(LINE_LIMIT - 1)) begin
                n_len = r_len + LW'(1);
                if (!r_bad) begin
                    if (r_prefix < PREFIX_LEN) begin
                        if (i_rx_byte != prefix_char(r_prefix)) begin
                            n_bad = 1'b1;
                        end else begin
                            n_prefix = r_prefix + 3'd1;
                        end
                    end else if (i_rx_byte == CHAR_COMMA) begin
                        n_inside = 1'b0;
                    end else begin
                        if (!r_inside) begin
                            if (r_field == FIELD_DATA) begin
                                w_skip = 1'b1;
                            end else begin
                                w_fld    = r_field + 2'd1;
                                n_field  = w_fld;
                                n_inside = 1'b1;
                            end
                        end
                        if (!w_skip && w_fld == FIELD_ADDR && !r_stopped) begin
                            if (i_rx_byte >= 8'h30 && i_rx_byte <= 8'h39) begin
                                n_addr = (w_addr_sum > 20'(ADDR_MAX)) ? ADDR_MAX
                                                                      : w_addr_sum[15:0];
                            end else begin
                                n_stopped = 1'b1;
                            end
                        end else if (!w_skip && w_fld == FIELD_DATA) begin
                            if (!w_hex[4]) begin
                                n_bad = 1'b1;
                            end else if (!r_phase) begin
                                n_high  = w_hex[3:0];
                                n_phase = 1'b1;
                            end else begin
                                n_phase = 1'b0;
                                if (r_count >= CW'(MAX_PAYLOAD)) begin
                                    n_bad = 1'b1;
                                end else begin
                                    w_we    = 1'b1;
                                    n_count = r_count + CW'(1);
                                end
                            end
                        end
                    end
                end
            end else begin
                n_len     = '0;
                n_prefix  = '0;
                n_field   = '0;
                n_inside  = 1'b0;
                n_addr    = '0;
                n_stopped = 1'b0;
                n_high    = '0;
                n_phase   = 1'b0;
                n_count   = '0;
                n_bad     = 1'b0;
            end
        end

        if (i_cmd.clear_line) begin
            n_len     = '0;
            n_prefix  = '0;
            n_field   = '0;
            n_inside  = 1'b0;
            n_addr    = '0;
            n_stopped = 1'b0;
            n_high    = '0;
            n_phase   = 1'b0;
            n_count   = '0;
            n_bad     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_prefix   <= '0;
            r_field    <= '0;
            r_inside   <= 1'b0;
            r_addr     <= '0;
            r_stopped  <= 1'b0;
            r_high     <= '0;
            r_phase    <= 1'b0;
            r_count    <= '0;
            r_bad      <= 1'b0;
            r_emit_idx <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_prefix  <= n_prefix;
            r_field   <= n_field;
            r_inside  <= n_inside;
            r_addr    <= n_addr;
            r_stopped <= n_stopped;
            r_high    <= n_high;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_bad     <= n_bad;
            if (i_cmd.clear_line) begin
                r_emit_idx <= '0;
            end else if (i_cmd.load) begin
                r_emit_idx <= r_emit_idx + CW'(1);
            end
            if (i_cmd.load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[AW-1:0]] <= w_wdata;
        end
    end

    // The output register doubles as the registered memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_data_byte      <= r_mem[r_emit_idx[AW-1:0]];
            o_sender_address <= r_addr;
            o_last_byte      <= w_emit_last;
        end
    end

    assign o_out_valid = r_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PAYLOAD))
        else $error("payload count beyond its limit");

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_emit_idx < r_count))
        else $error("emission index past the buffered payload");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_line |=> (r_count == '0 && r_emit_idx == '0 && r_len == '0))
        else $error("line clear left state behind");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |-> !i_cmd.load)
        else $error("pending output word overwritten");

endmodule

// ----- rtl/at_receive_frame_parser.sv -----
// A good frame's first result word is loaded into the output register from the emission
// state, which the controller enters when it accepts the frame's CR or LF; after that
// the output carries one word per cycle while the sink does not stall. The input takes
// one byte per cycle outside frame emission; while a frame's payload words are emitted,
// the input is stalled.
// Reset (synchronous, active low) clears the line state, the controller and the output
// valid; the payload memory is not cleared, since only bytes of the current line are read.
`timescale 1ns / 1ps

module at_receive_frame_parser #(
    parameter int LINE_LIMIT  = 1024,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_sender_address,
    output logic [7:0]  o_data_byte,
    output logic        o_last_byte
);
    import arfp_pkg::*;

    // The controller decides when a word is taken and when buffered payload bytes are
    // moved into the output register. The datapath holds the line parsing state, the
    // payload memory and that output register.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    arfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Because the output word sits in its own register, the next line's bytes may be
    // accepted while the final word of a frame still waits for the sink.
    arfp_dp #(
        .LINE_LIMIT  (LINE_LIMIT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_rx_byte        (i_rx_byte),
        .i_out_stall      (i_out_stall),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_sender_address (o_sender_address),
        .o_data_byte      (o_data_byte),
        .o_last_byte      (o_last_byte)
    );

endmodule

// ----- test/arfp_frame_checker.sv -----
// Checker for the receive frame parser: watches both word channels, predicts
// the frame words from the received bytes and compares them. Depends on arfp_pkg.
`timescale 1ns / 1ps

module arfp_frame_checker #(
    parameter int LINE_LIMIT  = 1024,
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_sender_address,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked
);
    import arfp_pkg::*;

    localparam logic [39:0] RCV_HEADER = "+RCV=";
    localparam logic [7:0]  CH_0 = "0";
    localparam logic [7:0]  CH_9 = "9";
    localparam logic [7:0]  CH_UA = "A";
    localparam logic [7:0]  CH_UF = "F";
    localparam logic [7:0]  CH_LA = "a";
    localparam logic [7:0]  CH_LF = "f";

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
    } t_rcv_word;

    t_rcv_word   frame_words_due[$];
    t_rcv_word   want;
    int          fails = 0;
    int          checked = 0;
    int          pending_count = 0;

    // Line parsing state of the prediction.
    int          line_len;
    logic [2:0]  hdr_pos;
    logic [1:0]  field_no;
    logic        in_field;
    int          addr_acc;
    logic        addr_done;
    logic [3:0]  hi_nib;
    logic        half;
    logic [7:0]  payload_mem [0:63];
    int          payload_len;
    logic        line_bad;

    assign o_fail_count    = fails;
    assign o_pending       = pending_count;
    assign o_words_checked = checked;

    task automatic clear_line_state();
        line_len    = 0;
        hdr_pos     = '0;
        field_no    = '0;
        in_field    = 1'b0;
        addr_acc    = 0;
        addr_done   = 1'b0;
        hi_nib      = '0;
        half        = 1'b0;
        payload_len = 0;
        line_bad    = 1'b0;
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    task automatic parse_line_char(input logic [7:0] c);
        int nib;
        int acc;
        if (!line_bad) begin
            if (hdr_pos < PREFIX_LEN) begin
                if (c != RCV_HEADER[39 - 8 * hdr_pos -: 8]) begin
                    line_bad = 1'b1;
                end else begin
                    hdr_pos++;
                end
            end else if (c == CHAR_COMMA) begin
                in_field = 1'b0;
            end else if (in_field || field_no < FIELD_DATA) begin
                // Characters of fields past the payload fall through untouched.
                if (!in_field) begin
                    field_no++;
                    in_field = 1'b1;
                end
                if (field_no == FIELD_ADDR) begin
                    if (!addr_done) begin
                        if (c >= CH_0 && c <= CH_9) begin
                            acc = addr_acc * 10 + int'(c - CH_0);
                            addr_acc = (acc > int'(ADDR_MAX)) ? int'(ADDR_MAX) : acc;
                        end else begin
                            addr_done = 1'b1;
                        end
                    end
                end else if (field_no == FIELD_DATA) begin
                    nib = hex_digit(c);
                    if (nib < 0) begin
                        line_bad = 1'b1;
                    end else if (!half) begin
                        hi_nib = nib[3:0];
                        half   = 1'b1;
                    end else begin
                        half = 1'b0;
                        if (payload_len >= MAX_PAYLOAD) begin
                            line_bad = 1'b1;
                        end else begin
                            payload_mem[payload_len] = {hi_nib, nib[3:0]};
                            payload_len++;
                        end
                    end
                end
            end
        end
    endtask

    task automatic predict_frame_words(input logic [7:0] c);
        t_rcv_word w;
        int k;
        if (c == CHAR_CR || c == CHAR_LF) begin
            if (line_len > 0) begin
                if (!line_bad && field_no == FIELD_DATA && !half && payload_len > 0
                        && payload_len <= MAX_PAYLOAD) begin
                    for (k = 0; k < payload_len; k++) begin
                        w.addr = addr_acc[15:0];
                        w.data = payload_mem[k];
                        w.last = (k == payload_len - 1);
                        frame_words_due.push_back(w);
                    end
                end
                clear_line_state();
            end
        end else if (line_len < LINE_LIMIT - 1) begin
            line_len++;
            parse_line_char(c);
        end else begin
            // The byte that would overflow the line is lost with the line.
            clear_line_state();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line_state();
            frame_words_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_words_due.size() == 0) begin
                    $error("unexpected word: sender_address %h data_byte %h last_byte %b",
                           i_sender_address, i_data_byte, i_last_byte);
                    fails++;
                end else begin
                    want = frame_words_due.pop_front();
                    checked++;
                    if (i_sender_address !== want.addr) begin
                        $error("sender_address: expected %h, actual %h",
                               want.addr, i_sender_address);
                        fails++;
                    end
                    if (i_data_byte !== want.data) begin
                        $error("data_byte: expected %h, actual %h", want.data, i_data_byte);
                        fails++;
                    end
                    if (i_last_byte !== want.last) begin
                        $error("last_byte: expected %b, actual %b", want.last, i_last_byte);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_frame_words(i_rx_byte);
            end
        end
        pending_count <= frame_words_due.size();
    end

endmodule

// ----- test/at_receive_frame_parser_tb.sv -----
// Testbench top for at_receive_frame_parser: drives received bytes and sink stalls,
// and gives the verdict. Depends on arfp_pkg, the parser and arfp_frame_checker.
`timescale 1ns / 1ps

module at_receive_frame_parser_tb;
    import arfp_pkg::*;

    localparam int LINE_LIMIT     = 1024;
    localparam int MAX_PAYLOAD    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 40;   // random bytes per flow-control phase
    localparam int MIN_RAND_WORDS = 48;   // random frames keep coming until this many words
    localparam int TAIL_CYCLES    = 20;
    localparam logic [7:0] FILL_CHAR = "x";
    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_LA = "a";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] sender_address;
    logic [7:0]  data_byte;
    logic        last_byte;

    int          fail_count;
    int          pending;
    int          words_checked;

    // Idle rates in percent; the stimulus process moves them from phase to phase.
    int          send_idle_pct = 12;
    int          recv_idle_pct = 56;

    int          bytes_sent = 0;
    int          lines_sent = 0;
    int          quiet_cycles = 0;
    logic [7:0]  line_q[$];

    always #6 clk = ~clk;

    at_receive_frame_parser #(
        .LINE_LIMIT  (LINE_LIMIT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_sender_address (sender_address),
        .o_data_byte      (data_byte),
        .o_last_byte      (last_byte)
    );

    arfp_frame_checker #(
        .LINE_LIMIT  (LINE_LIMIT),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_sender_address (sender_address),
        .i_data_byte      (data_byte),
        .i_last_byte      (last_byte),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_words_checked  (words_checked)
    );

    // The sink stalls at random, independently of what it is offered.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // The watchdog counts cycles in which no word moves on either channel. A hung
    // parser, or a frame whose words never arrive, ends the run here.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one byte, after a random idle gap, and returns at the edge that takes it.
    // The byte and valid hold steady while the parser stalls.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line();
        int k;
        for (k = 0; k < line_q.size(); k++) send_byte(line_q[k]);
        line_q.delete();
        lines_sent++;
    endtask

    task automatic push_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) line_q.push_back(s[k]);
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_line();
    endtask

    // Hex digit in random letter case, so both cases reach the payload decoder.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return CH_0 + n;
        return (($urandom_range(0, 1) != 0) ? CH_UA : CH_LA) + n - 4'd10;
    endfunction

    task automatic push_commas();
        int k;
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        for (k = 0; k < n; k++) line_q.push_back(CHAR_COMMA);
    endtask

    // A well-formed frame without its line ending: address, length and n payload bytes.
    task automatic push_frame(input int unsigned addr, input int n);
        int k;
        logic [7:0] b;
        push_text("+RCV=");
        if ($urandom_range(0, 7) == 0) push_text("00");
        push_text($sformatf("%0d", addr));
        push_commas();
        push_text($sformatf("%0d", n));
        push_commas();
        for (k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            line_q.push_back(hex_char(b[7:4]));
            line_q.push_back(hex_char(b[3:0]));
        end
    endtask

    // Mostly good frames with random content; some carry one corrupted byte, and
    // some lines are plain noise over the full byte range.
    task automatic push_random_line();
        int kind;
        int n;
        int k;
        int pos;
        int unsigned addr;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) line_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: addr = $urandom_range(0, 9);
                1: addr = $urandom_range(0, 65535);
                2: addr = $urandom_range(65536, 999999);
                default: addr = $urandom_range(0, 999);
            endcase
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_PAYLOAD + 1)
                                            : $urandom_range(1, 8);
            push_frame(addr, n);
            if ($urandom_range(0, 2) == 0) push_text(",-87,12");
            if (kind < 30) begin
                pos = $urandom_range(0, line_q.size() - 1);
                line_q[pos] = 8'($urandom_range(0, 255));
            end
        end
        case ($urandom_range(0, 2))
            0: line_q.push_back(CHAR_CR);
            1: line_q.push_back(CHAR_LF);
            default: begin
                line_q.push_back(CHAR_CR);
                line_q.push_back(CHAR_LF);
            end
        endcase
    endtask

    // The sender holds off until every predicted frame word has been taken.
    task automatic wait_for_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int phase;
        int phase_start;
        int words_at_start;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: empty lines, address extremes, both hex cases, comma runs,
        // trailing fields, and each way a frame can be refused.
        send_text("\r\n");
        send_text("+RCV=0,1,00\r");
        send_text("+RCV=65535,2,FF00\n");
        send_text("+RCV=99999,3,aBcDeF,-40,9\r\n");
        send_text("+RCV=12,,,5,,0f,\r");
        send_text("+RCX=1,1,00\r");
        send_text("+RCV=1,1\r");
        send_text("+RCV=1,1,0G\r");
        send_text("+RCV=1,1,012\r");
        send_text("+RCV=1,1,\r");
        send_text("+RCV=a12,1,55\r");
        send_text("+RCV=3x4,1,5a\r");

        // A zero byte ends the address digits but is no hex digit in the payload.
        push_text("+RCV=5");
        line_q.push_back(8'h00);
        send_text(",1,A5\r");
        push_text("+RCV=6,1,A");
        line_q.push_back(8'h00);
        send_text("5\r");

        // High-bit noise.
        line_q.push_back(8'hFF);
        line_q.push_back(8'h80);
        line_q.push_back(8'h7F);
        line_q.push_back(CHAR_CR);
        send_line();

        // Largest payload that is still taken, then one byte too many.
        push_frame(4660, MAX_PAYLOAD);
        line_q.push_back(CHAR_CR);
        send_line();
        push_frame(4661, MAX_PAYLOAD + 1);
        line_q.push_back(CHAR_LF);
        send_line();

        // A line that just fits the line buffer still yields its frame.
        push_text("+RCV=9,1,AB,");
        while (line_q.size() < LINE_LIMIT - 1) line_q.push_back(FILL_CHAR);
        line_q.push_back(CHAR_CR);
        send_line();

        // One byte more overflows: the line is dropped with that byte, and the
        // frame right behind it starts a fresh line.
        push_text("+RCV=9,1,CD,");
        while (line_q.size() < LINE_LIMIT) line_q.push_back(FILL_CHAR);
        send_text("+RCV=42,1,C3\n");

        wait_for_frames();

        // Random lines in three flow-control phases: slow sink, slow source, none.
        words_at_start = words_checked;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES
                    || (phase == 2 && words_checked - words_at_start < MIN_RAND_WORDS)) begin
                push_random_line();
                send_line();
            end
            wait_for_frames();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d lines; compared %0d frame words", bytes_sent,
                 lines_sent, words_checked);
        $display("under slow-sink, slow-source and full-rate flow control.");
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
